### sv/stbs_pkg.sv
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared types and codes for the sorted table binary search block.
// ----------------------------------------------------------------------------
package stbs_pkg;

  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 4;

  localparam logic [STATUS_W-1:0] STATUS_LOADED   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FOUND    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd3;

  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } state_t;

  // Link handed from one cell to the next one up the chain.
  typedef struct packed {
    logic                      valid;
    logic                      gt;
    logic signed [VALUE_W-1:0] value;
  } link_t;

endpackage

### sv/stbs_cell.sv
// ----------------------------------------------------------------------------
// stbs_cell
// One slot of the sorted chain: holds a value, compares it against the
// broadcast word and shifts up by one place on an ordered insert.
// ----------------------------------------------------------------------------
module stbs_cell (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               shift_en,
  input  logic signed [stbs_pkg::VALUE_W-1:0] bcast,
  input  stbs_pkg::link_t                    left,
  output stbs_pkg::link_t                    link,
  output logic                               eq
);

  logic                               valid_r;
  logic                               valid_nxt;
  logic signed [stbs_pkg::VALUE_W-1:0] value_r;
  logic signed [stbs_pkg::VALUE_W-1:0] value_nxt;
  logic                               gt;
  logic                               take;

  assign gt   = valid_r && (value_r > bcast);
  assign eq   = valid_r && (value_r == bcast);
  assign take = shift_en && (gt || (!valid_r && left.valid));

  always_comb begin
    valid_nxt = valid_r || (shift_en && left.valid);
    value_nxt = value_r;
    if (take) begin
      value_nxt = left.gt ? left.value : bcast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign link.valid = valid_r;
  assign link.gt    = gt;
  assign link.value = value_r;

endmodule

### sv/sorted_table_binary_search.sv
// ----------------------------------------------------------------------------
// sorted_table_binary_search
// Sorted value table with binary search lookup.
// ----------------------------------------------------------------------------
// Requests arrive on in_valid/in_ready with in_kind and in_value; each one
// yields exactly one result on out_valid/out_ready with out_status and
// out_position.
// A load request inserts its value in order into a chain of DEPTH cells in
// the cycle it is accepted; its result is registered and shows in the next
// cycle. Loads run at one per cycle while out_ready stays high. A load into
// a full table is dropped and answered with the full status.
// A search request walks a binary search over the chain, one midpoint per
// cycle, reading the compare flags of the cell at the midpoint. No request
// is taken while a search runs.
// The result register holds while out_ready is low; a new request is taken
// only when that register is empty or being emptied in the same cycle.
// Reset (rst_n low, synchronous) empties the table and drops any result.
// ----------------------------------------------------------------------------
module sorted_table_binary_search #(
  parameter int DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_kind,
  input  logic signed [stbs_pkg::VALUE_W-1:0] in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [stbs_pkg::STATUS_W-1:0]       out_status,
  output logic [stbs_pkg::POS_W-1:0]          out_position
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  stbs_pkg::state_t state_r, state_nxt;

  logic [CNT_W-1:0]                    count_r, count_nxt;
  logic [CNT_W-1:0]                    lo_r, lo_nxt;
  logic [CNT_W-1:0]                    hi_r, hi_nxt;
  logic signed [stbs_pkg::VALUE_W-1:0] key_r, key_nxt;
  logic                                out_valid_r, out_valid_nxt;
  logic [stbs_pkg::STATUS_W-1:0]       out_status_r, out_status_nxt;
  logic [stbs_pkg::POS_W-1:0]          out_pos_r, out_pos_nxt;

  logic                                accept;
  logic                                full;
  logic                                shift_en;
  logic signed [stbs_pkg::VALUE_W-1:0] bcast;
  logic [CNT_W:0]                      mid_sum;
  logic [IDX_W-1:0]                    mid;
  logic [IDX_W+stbs_pkg::POS_W-1:0]    mid_ext;
  logic [CNT_W-1:0]                    mid_cnt;
  logic                                search_end;
  logic                                mid_eq;
  logic                                mid_gt;

  stbs_pkg::link_t links [DEPTH+1];
  logic [DEPTH-1:0] eq_vec;
  logic [DEPTH-1:0] gt_vec;

  assign in_ready = (state_r == stbs_pkg::ST_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;
  assign full     = (count_r == CNT_W'(DEPTH));
  assign shift_en = accept && (in_kind == stbs_pkg::KIND_LOAD) && !full;
  assign bcast    = (state_r == stbs_pkg::ST_SEARCH) ? key_r : in_value;

  assign links[0].valid = 1'b1;
  assign links[0].gt    = 1'b0;
  assign links[0].value = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    stbs_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .bcast    (bcast),
      .left     (links[i]),
      .link     (links[i+1]),
      .eq       (eq_vec[i])
    );
    assign gt_vec[i] = links[i+1].gt;
  end

  assign mid_sum    = {1'b0, lo_r} + {1'b0, hi_r} - (CNT_W+1)'(1);
  assign mid        = mid_sum[IDX_W:1];
  assign mid_ext    = {{stbs_pkg::POS_W{1'b0}}, mid};
  assign mid_cnt    = CNT_W'(mid);
  assign search_end = (lo_r >= hi_r);
  assign mid_eq     = eq_vec[mid];
  assign mid_gt     = gt_vec[mid];

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      stbs_pkg::ST_IDLE: begin
        if (accept && (in_kind == stbs_pkg::KIND_SEARCH)) begin
          state_nxt = stbs_pkg::ST_SEARCH;
        end
      end
      stbs_pkg::ST_SEARCH: begin
        if (search_end || mid_eq) begin
          state_nxt = stbs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = stbs_pkg::ST_IDLE;
    endcase
  end

  // Datapath and result register
  always_comb begin
    count_nxt      = count_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    key_nxt        = key_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_pos_nxt    = out_pos_r;
    unique case (state_r)
      stbs_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_kind == stbs_pkg::KIND_LOAD) begin
            out_valid_nxt = 1'b1;
            out_pos_nxt   = '0;
            if (full) begin
              out_status_nxt = stbs_pkg::STATUS_FULL;
            end else begin
              out_status_nxt = stbs_pkg::STATUS_LOADED;
              count_nxt      = count_r + CNT_W'(1);
            end
          end else begin
            lo_nxt  = '0;
            hi_nxt  = count_r;
            key_nxt = in_value;
          end
        end
      end
      stbs_pkg::ST_SEARCH: begin
        priority if (search_end) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = stbs_pkg::STATUS_NOTFOUND;
          out_pos_nxt    = '0;
        end else if (mid_eq) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = stbs_pkg::STATUS_FOUND;
          out_pos_nxt    = mid_ext[stbs_pkg::POS_W-1:0];
        end else if (mid_gt) begin
          hi_nxt = mid_cnt;
        end else begin
          lo_nxt = mid_cnt + CNT_W'(1);
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= stbs_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    key_r        <= key_nxt;
    out_status_r <= out_status_nxt;
    out_pos_r    <= out_pos_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_position = out_pos_r;

endmodule
